// File: rtl/gif_lzw_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef GIF_LZW_DECODER_DEFINES_SVH
`define GIF_LZW_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define GLD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define GLD_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define GLD_ASSERT(lbl, clk, rstn, prop)
`define GLD_ASSERT_NEXT(lbl, clk, rstn, cond, expr)
`endif

`endif

// File: rtl/gld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int STACK_DEPTH_DEF   = 4096;
    localparam int ACC_BITS          = 24;
    localparam int ACC_CNT_W         = 5;
    localparam int BYTE_W            = 8;
    localparam int MIN_SIZE_W        = 4;
    localparam int REQ_W             = 2;
    localparam int STAT_W            = 3;

    localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RESET = 4'd8;
    localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_LO    = 4'd2;
    localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_HI    = 4'd8;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PULL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_PIXEL = 3'd0,
        STAT_TAKEN = 3'd1,
        STAT_NEED  = 3'd2,
        STAT_FULL  = 3'd3,
        STAT_END   = 3'd4,
        STAT_ERROR = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        K_PUSH,
        K_PULL,
        K_START,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_item;

endpackage
`default_nettype wire

// File: rtl/gif_lzw_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// GIF image-data LZW decoder.
// Input stream (s_axis): tuser selects the request (0 push byte, 1 pull pixel,
// 2 start image), tdata carries the raw stream byte for a push, including the
// sub-block count bytes. Every request answers with exactly one output transfer
// (m_axis): tdata is the pixel index, tuser the status (0 pixel, 1 byte taken,
// 2 need data, 3 buffer full, 4 end of image, 5 error).
// i_cfg_we/i_cfg_wdata load the LZW minimum code size; it takes effect at the
// next start request. Write it only while no request is outstanding.
// A push or start goes from S_IDLE to S_RESP and then into the output register.
// A pull passes through S_CHECK; one that pops a stacked pixel reads it in S_POP,
// one that decodes a code visits S_WALK and S_WUSE per prefix-chain entry, as
// the string table read is registered, and S_CHECK again per clear code skipped.
// A two-entry input queue takes new requests while the engine works or while
// a result waits; when the receiver stalls, the result holds and the queue
// fills, then s_axis_tready drops.
// Reset (synchronous, active low) empties the queue, sets min code size 8 and
// starts a fresh image; no clearing pass is needed.
`include "gif_lzw_decoder_defines.svh"
module gif_lzw_decoder #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
    parameter int STACK_DEPTH   = gld_pkg::STACK_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [gld_pkg::MIN_SIZE_W-1:0]  i_cfg_wdata,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [gld_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  wire  [gld_pkg::REQ_W-1:0]       s_axis_tuser,   // [1:0] req_type
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [gld_pkg::BYTE_W-1:0]      m_axis_tdata,   // [7:0] pixel_index
    output logic [gld_pkg::STAT_W-1:0]      m_axis_tuser    // [2:0] status
);
    import gld_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    gld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_pop     (q_pop)
    );

    gld_engine #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel     (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

    `GLD_ASSERT(a_pop_has_item, i_clk, i_rst_n, q_pop |-> q_valid)
    `GLD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tuser))
    `GLD_ASSERT(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser <= STAT_ERROR))

endmodule
`default_nettype wire

// File: rtl/gld_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gif_lzw_decoder_defines.svh"
module gld_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [gld_pkg::REQ_W-1:0]   i_req,
    input  wire  [gld_pkg::BYTE_W-1:0]  i_data,
    output logic                        o_q_valid,
    output gld_pkg::t_item              o_q_item,
    input  wire                         i_pop
);
    import gld_pkg::*;

    t_item      r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_kind      w_kind;
    logic       w_push;

    always_comb begin
        case (i_req)
            REQ_PUSH:  w_kind = K_PUSH;
            REQ_PULL:  w_kind = K_PULL;
            REQ_START: w_kind = K_START;
            default:   w_kind = K_BAD;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= '{kind: w_kind, data: i_data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    `GLD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'd2)
    `GLD_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_cnt != 2'd0))
    `GLD_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !w_push, r_cnt == $past(r_cnt) - 2'd1)

endmodule
`default_nettype wire

// File: rtl/gld_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gif_lzw_decoder_defines.svh"
module gld_engine #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
    parameter int STACK_DEPTH   = gld_pkg::STACK_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [gld_pkg::MIN_SIZE_W-1:0]  i_cfg_wdata,
    input  wire                             i_q_valid,
    input  gld_pkg::t_item                  i_q_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [gld_pkg::BYTE_W-1:0]      o_pixel,
    output logic [gld_pkg::STAT_W-1:0]      o_status
);
    import gld_pkg::*;

    localparam int W    = MAX_CODE_BITS;
    localparam int CWW  = $clog2(MAX_CODE_BITS + 1);
    localparam int SLW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int TABN = 1 << MAX_CODE_BITS;
    localparam logic [SLW-1:0] SDEPTH = SLW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_POP, S_WALK, S_WUSE, S_RESP
    } t_state;

    // table and stack storage
    logic [W+BYTE_W-1:0] r_tab [TABN];
    logic [BYTE_W-1:0]   r_stk [STACK_DEPTH];
    logic [W+BYTE_W-1:0] r_tab_q;
    logic [BYTE_W-1:0]   r_stk_q;

    logic                tab_we, tab_re, stk_we, stk_re;
    logic [W-1:0]        tab_wa, tab_ra;
    logic [W+BYTE_W-1:0] tab_wd;
    logic [SAW-1:0]      stk_wa, stk_ra;
    logic [BYTE_W-1:0]   stk_wd;

    t_state                r_state, n_state;
    logic [MIN_SIZE_W-1:0] r_min_size;
    logic [MIN_SIZE_W-1:0] r_msize, n_msize;
    logic [CWW-1:0]        r_cw, n_cw;
    logic [W:0]            r_nfree, n_nfree;
    logic [W:0]            r_wl, n_wl;
    logic [BYTE_W-1:0]     r_first, n_first;
    logic [W-1:0]          r_prev, n_prev;
    logic                  r_await, n_await;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic [ACC_CNT_W-1:0]  r_bits, n_bits;
    logic [BYTE_W-1:0]     r_blk, n_blk;
    logic                  r_dfin, n_dfin;
    logic                  r_ended, n_ended;
    logic [SLW-1:0]        r_sp, n_sp;
    logic [W-1:0]          r_walk, n_walk;
    logic [W-1:0]          r_incode, n_incode;
    logic [BYTE_W-1:0]     r_pix, n_pix;
    t_status               r_stat, n_stat;
    logic                  r_valid, n_valid;
    logic [BYTE_W-1:0]     r_opix, n_opix;
    t_status               r_ostat, n_ostat;

    logic [W-1:0]          cur_clear;
    logic [MIN_SIZE_W-1:0] clamp_size;

    assign cur_clear  = W'(1) << r_msize;
    assign clamp_size = (r_min_size < MIN_SIZE_LO) ? MIN_SIZE_LO :
                        (r_min_size > MIN_SIZE_HI) ? MIN_SIZE_HI : r_min_size;

    assign o_valid  = r_valid;
    assign o_pixel  = r_opix;
    assign o_status = r_ostat;

    always_comb begin
        logic [W-1:0]        code;
        logic [W-1:0]        link;
        logic [W-1:0]        nclear;
        logic [W:0]          nf;
        logic [ACC_BITS-1:0] mask;
        n_state  = r_state;
        n_msize  = r_msize;
        n_cw     = r_cw;
        n_nfree  = r_nfree;
        n_wl     = r_wl;
        n_first  = r_first;
        n_prev   = r_prev;
        n_await  = r_await;
        n_acc    = r_acc;
        n_bits   = r_bits;
        n_blk    = r_blk;
        n_dfin   = r_dfin;
        n_ended  = r_ended;
        n_sp     = r_sp;
        n_walk   = r_walk;
        n_incode = r_incode;
        n_pix    = r_pix;
        n_stat   = r_stat;
        n_valid  = r_valid && !i_ready;
        n_opix   = r_opix;
        n_ostat  = r_ostat;
        o_pop    = 1'b0;
        tab_we = 1'b0; tab_wa = r_nfree[W-1:0]; tab_wd = {r_prev, r_first};
        tab_re = 1'b0; tab_ra = r_walk;
        stk_we = 1'b0; stk_wa = r_sp[SAW-1:0];  stk_wd = r_first;
        stk_re = 1'b0; stk_ra = SAW'(r_sp - SLW'(1));
        mask   = (ACC_BITS'(1) << r_cw) - ACC_BITS'(1);
        code   = W'(r_acc & mask);
        link   = r_tab_q[W+BYTE_W-1:BYTE_W];
        nclear = W'(1) << clamp_size;
        nf     = r_nfree + (W+1)'(1);

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_pix   = '0;
                    n_state = S_RESP;
                    case (i_q_item.kind)
                        K_PUSH: begin
                            if (r_dfin || r_ended) begin
                                n_stat = STAT_END;
                            end else if (r_blk == '0) begin
                                if (i_q_item.data == '0) n_dfin = 1'b1;
                                else n_blk = i_q_item.data;
                                n_stat = STAT_TAKEN;
                            end else if (r_bits > ACC_CNT_W'(ACC_BITS - BYTE_W)) begin
                                n_stat = STAT_FULL;
                            end else begin
                                n_acc  = r_acc | (ACC_BITS'(i_q_item.data) << r_bits);
                                n_bits = r_bits + ACC_CNT_W'(BYTE_W);
                                n_blk  = r_blk - 8'd1;
                                n_stat = STAT_TAKEN;
                            end
                        end
                        K_PULL: n_state = S_CHECK;
                        K_START: begin
                            n_msize = clamp_size;
                            n_cw    = CWW'(clamp_size) + CWW'(1);
                            n_nfree = (W+1)'(nclear) + (W+1)'(2);
                            n_wl    = {nclear, 1'b0};
                            n_sp    = '0;
                            n_await = 1'b1;
                            n_first = '0;
                            n_prev  = '0;
                            n_acc   = '0;
                            n_bits  = '0;
                            n_blk   = '0;
                            n_dfin  = 1'b0;
                            n_ended = 1'b0;
                            n_stat  = STAT_TAKEN;
                        end
                        default: n_stat = STAT_ERROR;
                    endcase
                end
            end
            S_CHECK: begin
                n_state = S_RESP;
                n_pix   = '0;
                if (r_ended) begin
                    n_stat = STAT_END;
                end else if (r_sp != '0) begin
                    stk_re  = 1'b1;
                    n_sp    = r_sp - SLW'(1);
                    n_state = S_POP;
                end else if (r_bits < ACC_CNT_W'(r_cw)) begin
                    if (r_dfin) begin
                        n_ended = 1'b1;
                        n_stat  = STAT_ERROR;
                    end else begin
                        n_stat = STAT_NEED;
                    end
                end else begin
                    n_acc  = r_acc >> r_cw;
                    n_bits = r_bits - ACC_CNT_W'(r_cw);
                    if (code == cur_clear) begin
                        n_cw    = CWW'(r_msize) + CWW'(1);
                        n_nfree = (W+1)'(cur_clear) + (W+1)'(2);
                        n_wl    = {cur_clear, 1'b0};
                        n_await = 1'b1;
                        n_state = S_CHECK;
                    end else if (code == cur_clear + W'(1)) begin
                        n_ended = 1'b1;
                        n_stat  = STAT_END;
                    end else if (r_await) begin
                        if (code > cur_clear) begin
                            n_ended = 1'b1;
                            n_stat  = STAT_ERROR;
                        end else begin
                            n_first = BYTE_W'(code);
                            n_prev  = code;
                            n_await = 1'b0;
                            n_pix   = BYTE_W'(code);
                            n_stat  = STAT_PIXEL;
                        end
                    end else if ((W+1)'(code) > r_nfree) begin
                        n_ended = 1'b1;
                        n_stat  = STAT_ERROR;
                    end else begin
                        n_incode = code;
                        n_state  = S_WALK;
                        if ((W+1)'(code) == r_nfree) begin
                            // KwKwK: string of previous code plus its first char
                            stk_we = 1'b1;
                            n_sp   = r_sp + SLW'(1);
                            n_walk = r_prev;
                        end else begin
                            n_walk = code;
                        end
                    end
                end
            end
            S_POP: begin
                n_pix   = r_stk_q;
                n_stat  = STAT_PIXEL;
                n_state = S_RESP;
            end
            S_WALK: begin
                if (r_sp >= SDEPTH) begin
                    n_sp    = '0;
                    n_ended = 1'b1;
                    n_pix   = '0;
                    n_stat  = STAT_ERROR;
                    n_state = S_RESP;
                end else if (r_walk >= cur_clear) begin
                    tab_re  = 1'b1;
                    n_state = S_WUSE;
                end else begin
                    n_first = BYTE_W'(r_walk);
                    stk_we  = 1'b1;
                    stk_wd  = BYTE_W'(r_walk);
                    n_sp    = r_sp + SLW'(1);
                    if (!r_nfree[W]) begin
                        tab_we  = 1'b1;
                        tab_wd  = {r_prev, BYTE_W'(r_walk)};
                        n_nfree = nf;
                        if (nf >= r_wl && !r_wl[W]) begin
                            n_wl = {r_wl[W-1:0], 1'b0};
                            n_cw = r_cw + CWW'(1);
                        end
                    end
                    n_prev  = r_incode;
                    n_state = S_CHECK;
                end
            end
            S_WUSE: begin
                stk_we = 1'b1;
                stk_wd = r_tab_q[BYTE_W-1:0];
                n_sp   = r_sp + SLW'(1);
                if (link == r_walk) begin
                    n_sp    = '0;
                    n_ended = 1'b1;
                    n_pix   = '0;
                    n_stat  = STAT_ERROR;
                    n_state = S_RESP;
                end else begin
                    n_walk  = link;
                    n_state = S_WALK;
                end
            end
            S_RESP: begin
                if (!r_valid || i_ready) begin
                    n_valid = 1'b1;
                    n_opix  = r_pix;
                    n_ostat = r_stat;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab[tab_wa] <= tab_wd;
        if (tab_re) r_tab_q <= r_tab[tab_ra];
        if (stk_we) r_stk[stk_wa] <= stk_wd;
        if (stk_re) r_stk_q <= r_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min_size <= MIN_SIZE_RESET;
            r_msize    <= MIN_SIZE_RESET;
            r_cw       <= CWW'(MIN_SIZE_RESET) + CWW'(1);
            r_nfree    <= ((W+1)'(1) << MIN_SIZE_RESET) + (W+1)'(2);
            r_wl       <= (W+1)'(1) << (MIN_SIZE_RESET + 4'd1);
            r_first    <= '0;
            r_prev     <= '0;
            r_await    <= 1'b1;
            r_acc      <= '0;
            r_bits     <= '0;
            r_blk      <= '0;
            r_dfin     <= 1'b0;
            r_ended    <= 1'b0;
            r_sp       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_min_size <= i_cfg_wdata;
            r_msize <= n_msize;
            r_cw    <= n_cw;
            r_nfree <= n_nfree;
            r_wl    <= n_wl;
            r_first <= n_first;
            r_prev  <= n_prev;
            r_await <= n_await;
            r_acc   <= n_acc;
            r_bits  <= n_bits;
            r_blk   <= n_blk;
            r_dfin  <= n_dfin;
            r_ended <= n_ended;
            r_sp    <= n_sp;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_incode <= n_incode;
        r_pix    <= n_pix;
        r_stat   <= n_stat;
        r_opix   <= n_opix;
        r_ostat  <= n_ostat;
    end

    `GLD_ASSERT(a_stack_bound, i_clk, i_rst_n, r_sp <= SDEPTH)
    `GLD_ASSERT(a_width_bound, i_clk, i_rst_n, r_cw <= CWW'(MAX_CODE_BITS))
    `GLD_ASSERT(a_acc_bound, i_clk, i_rst_n, r_bits <= ACC_CNT_W'(ACC_BITS))
    `GLD_ASSERT_NEXT(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_RESP || r_state == S_CHECK)

endmodule
`default_nettype wire
